### src/pvh_pkg.sv
package pvh_pkg;

  localparam int unsigned BlockWidth = 128;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned LenWidth   = 37;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned BlockBytes = BlockWidth / 8;
  localparam int unsigned ProdWidth  = 2 * BlockWidth - 1;
  localparam int unsigned FoldRows   = ProdWidth - BlockWidth;

  // Item function codes
  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Configuration register indexes
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // x^128 mod P, with P = x^128 + x^127 + x^126 + x^121 + 1
  localparam logic [BlockWidth-1:0] RED_X128 = 128'hC2000000_00000000_00000000_00000001;
  // x^-128 mod P
  localparam logic [BlockWidth-1:0] XINV = 128'h92040000_00000000_00000000_00000001;

  typedef logic [FoldRows-1:0][BlockWidth-1:0] red_table_t;

  typedef struct packed {
    logic valid;
    logic finish;
  } stage_t;

  // Row k holds x^(128+k) mod P; evaluated at elaboration only.
  function automatic red_table_t build_red_table();
    red_table_t            tbl;
    logic [BlockWidth-1:0] r;
    logic                  carry;
    r      = RED_X128;
    tbl[0] = r;
    for (int k = 1; k < int'(FoldRows); k++) begin
      carry = r[BlockWidth-1];
      r = r << 1;
      if (carry) begin
        r = r ^ RED_X128;
      end
      tbl[k] = r;
    end
    return tbl;
  endfunction

  localparam red_table_t RED_TABLE = build_red_table();

endpackage

### src/pvh_gf_mult.sv
module pvh_gf_mult
  import pvh_pkg::*;
(
  input  logic [BlockWidth-1:0] a,
  input  logic [BlockWidth-1:0] b,
  output logic [BlockWidth-1:0] p
);

  logic [ProdWidth-1:0]  prod;
  logic [BlockWidth-1:0] folded;

  // Carry-less product: XOR of shifted copies of a
  always_comb begin
    prod = '0;
    for (int i = 0; i < int'(BlockWidth); i++) begin
      if (b[i]) begin
        prod = prod ^ (ProdWidth'(a) << i);
      end
    end
  end

  // Fold every high coefficient back through its x^k mod P row
  always_comb begin
    folded = prod[BlockWidth-1:0];
    for (int k = 0; k < int'(FoldRows); k++) begin
      if (prod[BlockWidth+k]) begin
        folded = folded ^ RED_TABLE[k];
      end
    end
  end

  assign p = folded;

endmodule

### src/pvh_key_store.sv
module pvh_key_store
  import pvh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [WordWidth-1:0]  cfg_data,
  output logic [BlockWidth-1:0] hkey
);

  logic [WordWidth-1:0]  key_low;
  logic [WordWidth-1:0]  key_high;
  logic [BlockWidth-1:0] key_next;
  logic [BlockWidth-1:0] hkey_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index)
      REG_KEY_LOW:  key_next = {key_high, cfg_data};
      REG_KEY_HIGH: key_next = {cfg_data, key_low};
      default:      key_next = {key_high, key_low};
    endcase
  end

  // Keep H * x^-128 ready so each item needs only one multiply
  pvh_gf_mult u_xinv_mult (
    .a (key_next),
    .b (XINV),
    .p (hkey_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      hkey     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_low  <= key_next[WordWidth-1:0];
      key_high <= key_next[BlockWidth-1:WordWidth];
      hkey     <= hkey_next;
    end
  end

endmodule

### src/pvh_in_stage.sv
module pvh_in_stage
  import pvh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [WordWidth-1:0]  block_low,
  input  logic [WordWidth-1:0]  block_high,
  input  logic [CountWidth-1:0] block_bytes,
  input  logic [LenWidth-1:0]   ad_bytes,
  input  logic [LenWidth-1:0]   text_bytes,
  input  logic                  hold,
  output stage_t                ctrl,
  output logic [BlockWidth-1:0] blk
);

  localparam logic [CountWidth-1:0] FullCount = CountWidth'(BlockBytes);
  localparam int unsigned PadWidth = WordWidth - LenWidth - 3;

  logic [CountWidth-1:0] nsat;
  logic [BlockWidth-1:0] mask;
  logic [BlockWidth-1:0] blk_next;

  assign nsat = (block_bytes > FullCount) ? FullCount : block_bytes;

  always_comb begin
    for (int k = 0; k < int'(BlockBytes); k++) begin
      mask[8*k +: 8] = {8{CountWidth'(k) < nsat}};
    end
  end

  // Finish items carry the length block, lengths in bits
  always_comb begin
    unique case (func)
      FUNC_FINISH: blk_next = {{PadWidth{1'b0}}, text_bytes, 3'b000,
                               {PadWidth{1'b0}}, ad_bytes, 3'b000};
      FUNC_ABSORB: blk_next = {block_high, block_low} & mask;
      default:     blk_next = '0;
    endcase
  end

  assign in_stall = ctrl.valid && hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (!in_stall) begin
      ctrl.valid  <= in_valid;
      ctrl.finish <= (func == FUNC_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      blk <= blk_next;
    end
  end

endmodule

### src/pvh_accum.sv
module pvh_accum
  import pvh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  stage_t                ctrl,
  input  logic [BlockWidth-1:0] blk,
  input  logic [BlockWidth-1:0] hkey,
  output logic                  hold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WordWidth-1:0]  digest_low,
  output logic [WordWidth-1:0]  digest_high
);

  logic [BlockWidth-1:0] acc;
  logic [BlockWidth-1:0] product;
  logic                  out_free;
  logic                  fire;

  pvh_gf_mult u_acc_mult (
    .a (acc ^ blk),
    .b (hkey),
    .p (product)
  );

  assign out_free = !out_valid || !out_stall;
  // A finish request waits while an untaken digest sits in the output register
  assign hold     = ctrl.finish && !out_free;
  assign fire     = ctrl.valid && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        if (ctrl.finish) begin
          acc <= '0;
        end else begin
          acc <= product;
        end
      end
      // Load a new digest, or drop the one just taken
      if (fire && ctrl.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.finish) begin
      digest_low  <= product[WordWidth-1:0];
      digest_high <= product[BlockWidth-1:WordWidth];
    end
  end

endmodule

### src/polyval_hash_accumulator_top.sv
// POLYVAL hash accumulator over GF(2^128).
// Configuration: write the key halves through cfg_valid/cfg_ready with
// cfg_index 0 (bytes 0-7) or 1 (bytes 8-15); cfg_ready is always high, and
// the derived key H*x^-128 is formed on the write itself.
// Input channel (in_valid/in_stall): func 0 absorbs a data block with
// block_bytes valid bytes, func 1 absorbs the length block built from
// ad_bytes and text_bytes, emits the digest and clears the accumulator.
// Output channel (out_valid/out_stall) carries one digest per finish request.
// Throughput: one request per cycle while in_stall is low, set by the
// combinational multiply and reduction that closes the accumulator loop.
// A finish request accepted into the input register loads its digest into
// the output register when it fires, and the digest is taken from there.
// While a digest waits under out_stall, data requests keep flowing; a
// following finish request holds in the input register and raises in_stall.
// Reset clears the key, the accumulator and both valid flags.
module polyval_hash_accumulator_top
  import pvh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [WordWidth-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [WordWidth-1:0]  block_low,
  input  logic [WordWidth-1:0]  block_high,
  input  logic [CountWidth-1:0] block_bytes,
  input  logic [LenWidth-1:0]   ad_bytes,
  input  logic [LenWidth-1:0]   text_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WordWidth-1:0]  digest_low,
  output logic [WordWidth-1:0]  digest_high
);

  logic [BlockWidth-1:0] hkey;
  logic [BlockWidth-1:0] blk;
  stage_t                ctrl;
  logic                  hold;

  pvh_key_store u_key_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hkey      (hkey)
  );

  pvh_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .block_low   (block_low),
    .block_high  (block_high),
    .block_bytes (block_bytes),
    .ad_bytes    (ad_bytes),
    .text_bytes  (text_bytes),
    .hold        (hold),
    .ctrl        (ctrl),
    .blk         (blk)
  );

  pvh_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .blk         (blk),
    .hkey        (hkey),
    .hold        (hold),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_low  (digest_low),
    .digest_high (digest_high)
  );

endmodule
